### rtl/rmq_pkg.sv
package rmq_pkg;

   localparam int FRAC_BITS = 14;

   // Stage map: front end, one stage per root digit, divider setup,
   // one stage per quotient bit, output formatting.
   localparam int SQRT_STEPS = 16;
   localparam int DIV_STEPS  = 16;
   localparam int PREP_STAGE = SQRT_STEPS + 1;
   localparam int OUT_STAGE  = PREP_STAGE + DIV_STEPS + 1;
   localparam int NUM_STAGES = OUT_STAGE + 1;

   localparam logic [1:0] BR_TRACE  = 2'd0;
   localparam logic [1:0] BR_PIVOT0 = 2'd1;
   localparam logic [1:0] BR_PIVOT1 = 2'd2;
   localparam logic [1:0] BR_PIVOT2 = 2'd3;

   localparam logic [14:0] TOL_RESET = 15'd16;

   typedef struct packed {
      logic [17:0] rem;
      logic [15:0] qt;
   } div_state_type;

   typedef struct packed {
      logic [1:0]        code;
      logic [31:0]       rad;
      logic [17:0]       srem;
      logic [15:0]       root;
      logic [2:0][16:0]  num;
      logic [16:0]       dvs;
      logic [15:0]       pivot;
      logic [2:0]        neg;
      logic [2:0]        zero;
      logic [2:0]        sat;
      logic [2:0][30:0]  mag;
      logic [2:0][17:0]  rem;
      logic [2:0][15:0]  qt;
      logic [3:0][15:0]  quat;
   } stage_type;

endpackage

### rtl/rotation_matrix_to_quaternion_top.sv
// Converts a 3x3 rotation matrix (Q2.14 elements on req_m00..req_m22) into
// a quaternion (rsp_quat_w..rsp_quat_z, Q2.14) plus rsp_branch_code, which
// is 0 for the trace branch and 1..3 for the pivot on diagonal 0..2.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// csr_wr_en writes csr_wr_data into the trace tolerance register at once;
// it is to be written only while the block is empty; the block does not enforce it.
// The block is a 35-stage pipeline: one front-end stage, 16 square root
// digit stages, a divider setup stage, 16 quotient bit stages for the three
// parallel dividers, and the output register. A beat passes through every
// stage in order to the result channel; a new beat can enter in every cycle
// unless a stalled receiver has filled every stage, so throughput is one matrix per cycle.
// Each stage advances whenever it is empty or the stage after it advances,
// so when the receiver stalls the pipeline fills up, bubbles collapse, and
// req_ready falls only once every stage holds a beat.
// Reset clears all valid bits and loads the tolerance with 16.
module rotation_matrix_to_quaternion_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_m00,
   input  logic signed [15:0] req_m01,
   input  logic signed [15:0] req_m02,
   input  logic signed [15:0] req_m10,
   input  logic signed [15:0] req_m11,
   input  logic signed [15:0] req_m12,
   input  logic signed [15:0] req_m20,
   input  logic signed [15:0] req_m21,
   input  logic signed [15:0] req_m22,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic [1:0]         rsp_branch_code,
   input  logic               csr_wr_en,
   input  logic [14:0]        csr_wr_data
);

   localparam int NS = rmq_pkg::NUM_STAGES;
   localparam logic signed [17:0] ONE = 18'sd1 <<< rmq_pkg::FRAC_BITS;

   logic [14:0]         tol_ff;
   logic [NS-1:0]       valid_ff;
   logic [NS:0]         stage_en;
   rmq_pkg::stage_type  stage_ff [NS];

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= rmq_pkg::TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   always_comb begin
      stage_en[NS] = rsp_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_ready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_stage
      rmq_pkg::stage_type nx;

      if (k == 0) begin : g_front
         logic signed [17:0] a00, a11, a22, msum, cur, radp;
         logic [1:0]         p;
         always_comb begin
            nx   = '0;
            a00  = 18'(req_m00);
            a11  = 18'(req_m11);
            a22  = 18'(req_m22);
            msum = ONE + a00 + a11 + a22;
            p    = 2'd0;
            cur  = a00;
            radp = '0;
            if (msum > $signed({3'b000, tol_ff})) begin
               nx.code   = rmq_pkg::BR_TRACE;
               nx.rad    = 32'(msum) << rmq_pkg::FRAC_BITS;
               nx.num[0] = 17'(req_m21) - 17'(req_m12);
               nx.num[1] = 17'(req_m02) - 17'(req_m20);
               nx.num[2] = 17'(req_m10) - 17'(req_m01);
            end else begin
               if (a11 > cur) begin
                  p   = 2'd1;
                  cur = a11;
               end
               if (a22 > cur) begin
                  p   = 2'd2;
                  cur = a22;
               end
               radp = ONE + cur;
               if (radp < 0) begin
                  radp = '0;
               end
               nx.rad = 32'(radp) << (rmq_pkg::FRAC_BITS - 1);
               // Slot 0 holds the next axis after the pivot, slot 1 the one after that.
               case (p)
                  2'd0: begin
                     nx.code   = rmq_pkg::BR_PIVOT0;
                     nx.num[0] = 17'(req_m01) + 17'(req_m10);
                     nx.num[1] = 17'(req_m20) + 17'(req_m02);
                  end
                  2'd1: begin
                     nx.code   = rmq_pkg::BR_PIVOT1;
                     nx.num[0] = 17'(req_m12) + 17'(req_m21);
                     nx.num[1] = 17'(req_m01) + 17'(req_m10);
                  end
                  default: begin
                     nx.code   = rmq_pkg::BR_PIVOT2;
                     nx.num[0] = 17'(req_m20) + 17'(req_m02);
                     nx.num[1] = 17'(req_m12) + 17'(req_m21);
                  end
               endcase
            end
         end
      end else if (k <= rmq_pkg::SQRT_STEPS) begin : g_sqrt
         localparam int J = k - 1;
         logic [19:0] sh;
         logic [17:0] trial;
         always_comb begin
            nx    = stage_ff[k-1];
            sh    = {stage_ff[k-1].srem, stage_ff[k-1].rad[31-2*J -: 2]};
            trial = {stage_ff[k-1].root, 2'b01};
            if (sh >= 20'(trial)) begin
               nx.srem = 18'(sh - 20'(trial));
               nx.root = {stage_ff[k-1].root[14:0], 1'b1};
            end else begin
               nx.srem = sh[17:0];
               nx.root = {stage_ff[k-1].root[14:0], 1'b0};
            end
         end
      end else if (k == rmq_pkg::PREP_STAGE) begin : g_prep
         logic [15:0] div;
         logic [16:0] anum;
         always_comb begin
            nx   = stage_ff[k-1];
            anum = '0;
            if (stage_ff[k-1].code == rmq_pkg::BR_TRACE) begin
               div = {1'b0, stage_ff[k-1].root[15:1]};
            end else begin
               div = stage_ff[k-1].root;
            end
            nx.pivot = div;
            nx.dvs   = {div[14:0], 2'b00};
            for (int i = 0; i < 3; i++) begin
               nx.neg[i] = stage_ff[k-1].num[i][16];
               if (stage_ff[k-1].num[i][16]) begin
                  anum = 17'd0 - stage_ff[k-1].num[i];
               end else begin
                  anum = stage_ff[k-1].num[i];
               end
               nx.zero[i] = (div == '0);
               nx.mag[i]  = 31'(anum) << rmq_pkg::FRAC_BITS;
               nx.sat[i]  = {2'b00, nx.mag[i]} >= {div[14:0], 2'b00, 16'd0};
               nx.rem[i]  = 18'(nx.mag[i][30:16]);
               nx.qt[i]   = '0;
            end
         end
      end else if (k < rmq_pkg::OUT_STAGE) begin : g_div
         localparam int J = k - rmq_pkg::PREP_STAGE - 1;
         rmq_pkg::div_state_type ds_in  [3];
         rmq_pkg::div_state_type ds_out [3];
         for (genvar i = 0; i < 3; i++) begin : g_lane
            assign ds_in[i].rem = stage_ff[k-1].rem[i];
            assign ds_in[i].qt  = stage_ff[k-1].qt[i];
            rmq_div_step u_step (
               .st_in  (ds_in[i]),
               .bit_in (stage_ff[k-1].mag[i][15-J]),
               .dvs    (stage_ff[k-1].dvs),
               .st_out (ds_out[i])
            );
         end
         always_comb begin
            nx = stage_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               nx.rem[i] = ds_out[i].rem;
               nx.qt[i]  = ds_out[i].qt;
            end
         end
      end else begin : g_out
         logic [2:0][15:0] res;
         always_comb begin
            nx = stage_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               if (stage_ff[k-1].zero[i]) begin
                  if (stage_ff[k-1].neg[i]) begin
                     res[i] = 16'h8000;
                  end else if (stage_ff[k-1].num[i] != '0) begin
                     res[i] = 16'h7FFF;
                  end else begin
                     res[i] = '0;
                  end
               end else if (stage_ff[k-1].neg[i]) begin
                  if (stage_ff[k-1].sat[i] || stage_ff[k-1].qt[i] > 16'd32768) begin
                     res[i] = 16'h8000;
                  end else begin
                     res[i] = 16'd0 - stage_ff[k-1].qt[i];
                  end
               end else begin
                  if (stage_ff[k-1].sat[i] || stage_ff[k-1].qt[i] > 16'd32767) begin
                     res[i] = 16'h7FFF;
                  end else begin
                     res[i] = stage_ff[k-1].qt[i];
                  end
               end
            end
            case (stage_ff[k-1].code)
               rmq_pkg::BR_TRACE: begin
                  nx.quat = {res[2], res[1], res[0], stage_ff[k-1].pivot};
               end
               rmq_pkg::BR_PIVOT0: begin
                  nx.quat = {res[1], res[0], stage_ff[k-1].pivot, 16'd0};
               end
               rmq_pkg::BR_PIVOT1: begin
                  nx.quat = {res[0], stage_ff[k-1].pivot, res[1], 16'd0};
               end
               default: begin
                  nx.quat = {stage_ff[k-1].pivot, res[1], res[0], 16'd0};
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            stage_ff[k] <= nx;
         end
      end
   end

   assign rsp_valid       = valid_ff[NS-1];
   assign rsp_quat_w      = stage_ff[NS-1].quat[0];
   assign rsp_quat_x      = stage_ff[NS-1].quat[1];
   assign rsp_quat_y      = stage_ff[NS-1].quat[2];
   assign rsp_quat_z      = stage_ff[NS-1].quat[3];
   assign rsp_branch_code = stage_ff[NS-1].code;

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_trace_w : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_code == rmq_pkg::BR_TRACE |-> rsp_quat_w > 16'sd0)
      else $error("trace branch gave a non-positive w");

   a_pivot_w : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_code != rmq_pkg::BR_TRACE |-> rsp_quat_w == 16'sd0)
      else $error("pivot branch gave a nonzero w");

   a_pivot_x : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_code == rmq_pkg::BR_PIVOT0 |-> !rsp_quat_x[15])
      else $error("pivot component on axis 0 is negative");

endmodule

### rtl/rmq_div_step.sv
module rmq_div_step (
   input  rmq_pkg::div_state_type st_in,
   input  logic                   bit_in,
   input  logic [16:0]            dvs,
   output rmq_pkg::div_state_type st_out
);

   logic [17:0] rem_sh;

   always_comb begin
      rem_sh = {st_in.rem[16:0], bit_in};
      if (rem_sh >= {1'b0, dvs}) begin
         st_out.rem = rem_sh - {1'b0, dvs};
         st_out.qt  = {st_in.qt[14:0], 1'b1};
      end else begin
         st_out.rem = rem_sh;
         st_out.qt  = {st_in.qt[14:0], 1'b0};
      end
   end

endmodule
